FILE: hdl/vlmf_pkg.sv
// ----------------------------------------------------------------------------
// vlmf_pkg
// Shared types, register codes and the saturating adder for the voxel label
// fusion block.
// ----------------------------------------------------------------------------
package vlmf_pkg;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_LABELS  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LOG   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NONMATCH_LOG = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_LOG    = 4'd3;

	localparam logic [5:0]  NUM_LABELS_RST   = 6'd32;
	localparam logic [31:0] MATCH_LOG_RST    = 32'(-14564);
	localparam logic [31:0] NONMATCH_LOG_RST = 32'(-69075);
	localparam logic [31:0] INIT_LOG_RST     = 32'(-227130);

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	// register file contents seen by the update engine
	typedef struct packed {
		logic [5:0]  num_labels;
		logic [31:0] match_log;
		logic [31:0] nonmatch_log;
		logic [31:0] init_log;
	} cfg_t;

	// one classified observation
	typedef struct packed {
		logic [7:0] vox;    // voxel index
		logic [7:0] lab;    // label, meaningful only when upd is set
		logic [8:0] count;  // labels in use
		logic       inr;    // voxel index within the store
		logic       upd;    // scores are to be updated
	} obs_t;

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return s[31:0];
	endfunction

endpackage

FILE: hdl/vlmf_front.sv
// ----------------------------------------------------------------------------
// vlmf_front
// Configuration registers and observation classification ahead of the queue.
// ----------------------------------------------------------------------------
module vlmf_front #(
	parameter int NUM_VOXELS = 256,
	parameter int MAX_LABELS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vlmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [vlmf_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [7:0] voxel_index, [23:8] label
	output vlmf_pkg::cfg_t                 cfg,
	output logic                           push,
	input  logic                           push_ready,
	output vlmf_pkg::obs_t                 push_data
);
	import vlmf_pkg::*;

	cfg_t       cfg_q;
	logic [7:0] vox;
	logic [15:0] lab;
	logic [8:0] count;
	logic       inr;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_labels   <= NUM_LABELS_RST;
			cfg_q.match_log    <= MATCH_LOG_RST;
			cfg_q.nonmatch_log <= NONMATCH_LOG_RST;
			cfg_q.init_log     <= INIT_LOG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NUM_LABELS:   cfg_q.num_labels   <= cfg_data[5:0];
				CFG_MATCH_LOG:    cfg_q.match_log    <= cfg_data;
				CFG_NONMATCH_LOG: cfg_q.nonmatch_log <= cfg_data;
				CFG_INIT_LOG:     cfg_q.init_log     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign vox   = s_axis_tdata[7:0];
	assign lab   = s_axis_tdata[23:8];
	// cap the register at the built label count
	assign count = (9'(cfg_q.num_labels) < 9'(MAX_LABELS)) ? 9'(cfg_q.num_labels)
		: 9'(MAX_LABELS);
	assign inr   = 32'(vox) < NUM_VOXELS;

	assign push_data.vox   = vox;
	assign push_data.lab   = lab[7:0];
	assign push_data.count = count;
	assign push_data.inr   = inr;
	assign push_data.upd   = inr && (lab < 16'(count));

	assign push          = s_axis_tvalid && push_ready;
	assign s_axis_tready = push_ready;

endmodule

FILE: hdl/vlmf_queue.sv
// ----------------------------------------------------------------------------
// vlmf_queue
// Two-entry queue of classified observations between front and back.
// ----------------------------------------------------------------------------
module vlmf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  vlmf_pkg::obs_t push_data,
	input  logic           pop,
	output logic           pop_valid,
	output vlmf_pkg::obs_t pop_data
);
	import vlmf_pkg::*;

	obs_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hdl/vlmf_back.sv
// ----------------------------------------------------------------------------
// vlmf_back
// Score update engine: one score read, saturating add, write-back and running argmax per
// cycle, then label store update and result register; an ignored observation only sets the result.
// ----------------------------------------------------------------------------
module vlmf_back #(
	parameter int NUM_VOXELS = 256,
	parameter int MAX_LABELS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vlmf_pkg::cfg_t                  cfg,
	input  logic                            pop_valid,
	output logic                            pop,
	input  vlmf_pkg::obs_t                  pop_data,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [vlmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] voxel_id, [12:8] best_label
	output logic                            m_axis_tuser   // accepted
);
	import vlmf_pkg::*;

	localparam int NV_EFF = (NUM_VOXELS < 256) ? NUM_VOXELS : 256;
	localparam int VIW    = (NV_EFF > 1) ? $clog2(NV_EFF) : 1;
	localparam int LW     = $clog2(MAX_LABELS);
	localparam int AW     = $clog2(NV_EFF * MAX_LABELS);

	typedef enum logic [2:0] {ST_IDLE, ST_LOOK, ST_RUN, ST_DRAIN, ST_OUT} state_t;

	state_t          state_q;
	logic [NV_EFF-1:0] empty_q;
	logic [31:0]     score_mem [NV_EFF * MAX_LABELS];
	logic [4:0]      label_mem [NV_EFF];

	obs_t            ent_q;
	logic [AW-1:0]   base_q;
	logic [4:0]      lbl_rd_q;
	logic            vempty_q;
	logic [LW-1:0]   idx_q;
	logic            last;
	logic            fin;

	logic            v_s1;
	logic [LW-1:0]   l_s1;
	logic [31:0]     rd_s1;
	logic            v_s2;
	logic [LW-1:0]   l_s2;
	logic [31:0]     sum_s2;
	logic [31:0]     top_q;
	logic [LW-1:0]   best_q;

	logic            res_acc_q;
	logic [4:0]      res_best_q;

	logic [31:0]     op_a;
	logic [31:0]     op_b;
	logic [VIW-1:0]  pop_vox;
	logic [VIW-1:0]  ent_vox;

	assign pop     = (state_q == ST_IDLE);
	assign pop_vox = pop_data.vox[VIW-1:0];
	assign ent_vox = ent_q.vox[VIW-1:0];
	assign last    = (9'(idx_q) == ent_q.count - 9'd1);
	// pipeline empty once the last score is written
	assign fin     = (state_q == ST_DRAIN) && !v_s1 && !v_s2;

	assign op_a = vempty_q ? cfg.init_log : rd_s1;
	assign op_b = (l_s1 == ent_q.lab[LW-1:0]) ? cfg.match_log : cfg.nonmatch_log;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			empty_q       <= '1;
			idx_q         <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			res_acc_q     <= 1'b0;
			res_best_q    <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			// the output state loads the next beat itself
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_OUT)) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (ent_q.upd) begin
						idx_q   <= '0;
						state_q <= ST_RUN;
					end else begin
						res_acc_q  <= 1'b0;
						res_best_q <= (!ent_q.inr || vempty_q) ? 5'd0 : lbl_rd_q;
						state_q    <= ST_OUT;
					end
				end
				ST_RUN: begin
					idx_q <= idx_q + LW'(1);
					if (last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (fin) begin
						empty_q[ent_vox] <= 1'b0;
						res_acc_q        <= 1'b1;
						res_best_q       <= 5'(best_q);
						state_q          <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {3'b000, res_best_q, ent_q.vox};
						m_axis_tuser  <= res_acc_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_valid) begin
			ent_q    <= pop_data;
			base_q   <= AW'(32'(pop_vox) * MAX_LABELS);
			lbl_rd_q <= label_mem[pop_vox];
			vempty_q <= empty_q[pop_vox];
		end
		// read stage
		if (state_q == ST_RUN) begin
			rd_s1 <= score_mem[base_q + AW'(idx_q)];
		end
		l_s1   <= idx_q;
		// add stage
		sum_s2 <= sat_add(op_a, op_b);
		l_s2   <= l_s1;
		// write back and argmax, lowest label wins a tie
		if (v_s2) begin
			score_mem[base_q + AW'(l_s2)] <= sum_s2;
			if ((l_s2 == '0) || ($signed(sum_s2) > $signed(top_q))) begin
				top_q  <= sum_s2;
				best_q <= l_s2;
			end
		end
		if (fin) begin
			label_mem[ent_vox] <= 5'(best_q);
		end
	end

endmodule

FILE: hdl/voxel_label_mle_fusion.sv
// An update steps through count label scores of its voxel, one per cycle, where count
// is num_labels capped at MAX_LABELS; an ignored observation touches no scores. The
// engine takes the next observation only once the last result beat is loaded, so the
// two-entry queue holds arriving observations meanwhile.
// Reset clears all voxels to the unstarted state at once, with no clearing pass,
// and loads the register defaults; the score memory itself is not cleared.
module voxel_label_mle_fusion #(
	parameter int NUM_VOXELS = 256,
	parameter int MAX_LABELS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vlmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [vlmf_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [7:0] voxel_index, [23:8] label
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [vlmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [7:0] voxel_id, [12:8] best_label
	output logic                            m_axis_tuser   // accepted
);
	import vlmf_pkg::*;

	cfg_t cfg;
	logic push;
	logic push_ready;
	obs_t push_data;
	logic pop;
	logic pop_valid;
	obs_t pop_data;

	vlmf_front #(
		.NUM_VOXELS(NUM_VOXELS),
		.MAX_LABELS(MAX_LABELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.cfg          (cfg),
		.push         (push),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	vlmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	vlmf_back #(
		.NUM_VOXELS(NUM_VOXELS),
		.MAX_LABELS(MAX_LABELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pop_valid    (pop_valid),
		.pop          (pop),
		.pop_data     (pop_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

FILE: hdl/vlmf_checker.sv
// ----------------------------------------------------------------------------
// vlmf_checker
// Port-level checks on the result stream of the voxel label fusion block.
// ----------------------------------------------------------------------------
module vlmf_checker #(
	parameter int NUM_VOXELS = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	logic [3:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// count observations still owed a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 4'd1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pend_q != 4'd0)
		else $error("result beat with no observation outstanding");

	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (32'(m_axis_tdata[7:0]) >= NUM_VOXELS)
		|-> !m_axis_tuser && (m_axis_tdata[12:8] == 5'd0))
		else $error("voxel outside the store reported as updated");

endmodule

bind voxel_label_mle_fusion vlmf_checker #(
	.NUM_VOXELS(NUM_VOXELS)
) u_vlmf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
